### sv/deqi_pkg.sv
package deqi_pkg;

    // Capacity and element width of the queue.
    localparam int DEPTH      = 256;
    localparam int DATA_WIDTH = 32;

    // Port widths fixed by the interface.
    localparam int OP_W   = 2;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 8;
    localparam int CNTO_W = 9;
    localparam int ST_W   = 2;

    // Internal widths derived from the capacity.
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = ((ADDR_W > POS_W) ? ADDR_W : POS_W) + 1;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ       = 2'd2;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // Memory access and outcome of one operation, from the pointer unit.
    typedef struct packed {
        logic              wr_en;
        logic              rd_ok;
        logic [ADDR_W-1:0] addr;
        logic [ST_W-1:0]   status;
    } deqi_ctl_t;

endpackage

### sv/deqi_ram.sv
module deqi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/deqi_ptr.sv
module deqi_ptr (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      take,
    input  logic [deqi_pkg::OP_W-1:0]  opcode,
    input  logic [deqi_pkg::POS_W-1:0] position,
    output deqi_pkg::deqi_ctl_t       ctl,
    output logic [deqi_pkg::CNT_W-1:0] count
);

    import deqi_pkg::*;

    logic [ADDR_W-1:0] head_reg;
    logic [ADDR_W-1:0] head_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [ADDR_W-1:0] front_slot;
    logic [ADDR_W-1:0] back_slot;
    logic [ADDR_W-1:0] read_slot;
    logic [SUM_W-1:0]  back_sum;
    logic [SUM_W-1:0]  read_sum;
    logic              full;

    // Ring arithmetic: each sum stays below twice the depth, so one
    // compare and subtract wraps it.
    always_comb
    begin
        full       = (count_reg == CNT_W'(DEPTH));
        front_slot = (head_reg == '0) ? ADDR_W'(DEPTH - 1) : head_reg - ADDR_W'(1);
        back_sum   = SUM_W'(head_reg) + SUM_W'(count_reg);
        read_sum   = SUM_W'(head_reg) + SUM_W'(position);
        if (back_sum >= SUM_W'(DEPTH))
        begin
            back_slot = ADDR_W'(back_sum - SUM_W'(DEPTH));
        end
        else
        begin
            back_slot = ADDR_W'(back_sum);
        end
        if (read_sum >= SUM_W'(DEPTH))
        begin
            read_slot = ADDR_W'(read_sum - SUM_W'(DEPTH));
        end
        else
        begin
            read_slot = ADDR_W'(read_sum);
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        ctl        = '0;
        ctl.status = ST_OK;
        case (opcode)
            OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    ctl.status = ST_FULL;
                end
                else
                begin
                    ctl.wr_en  = 1'b1;
                    ctl.addr   = front_slot;
                    head_next  = front_slot;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_PUSH_BACK:
            begin
                if (full)
                begin
                    ctl.status = ST_FULL;
                end
                else
                begin
                    ctl.wr_en  = 1'b1;
                    ctl.addr   = back_slot;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_READ:
            begin
                if (SUM_W'(position) >= SUM_W'(count_reg))
                begin
                    ctl.status = ST_RANGE;
                end
                else
                begin
                    ctl.rd_ok = 1'b1;
                    ctl.addr  = read_slot;
                end
            end
            default:
            begin
                ctl.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else if (take)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count exceeds capacity");

    // A refused push leaves head and count alone.
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (take && ctl.status == ST_FULL) |=>
            (count_reg == $past(count_reg) && head_reg == $past(head_reg)))
        else $error("refused push changed the queue");

endmodule

### sv/double_ended_queue_indexed.sv
// Channel   Handshake           Payload
// command   start / busy        opcode, value, position
// result    done (one cycle)    read_data, front_value, back_value, ends_valid,
//                               element_count, is_empty, status
//
// One operation is taken per clock cycle; busy stays low.
// Each result appears on the cycle after its command transfer, for exactly one cycle.
// Results are registered, and read_data comes from the registered read of the element memory.
// Reset clears the head pointer, the count and the end copies; the memory is not cleared.
// The receiver cannot stall, so nothing ever holds a result back.
module double_ended_queue_indexed (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [deqi_pkg::OP_W-1:0]   opcode,
    input  logic [deqi_pkg::VAL_W-1:0]  value,
    input  logic [deqi_pkg::POS_W-1:0]  position,
    output logic                       done,
    output logic [deqi_pkg::VAL_W-1:0]  read_data,
    output logic [deqi_pkg::VAL_W-1:0]  front_value,
    output logic [deqi_pkg::VAL_W-1:0]  back_value,
    output logic                       ends_valid,
    output logic [deqi_pkg::CNTO_W-1:0] element_count,
    output logic                       is_empty,
    output logic [deqi_pkg::ST_W-1:0]   status
);

    import deqi_pkg::*;

    logic                  take;
    deqi_ctl_t             ctl;
    logic [CNT_W-1:0]      count;
    logic [DATA_WIDTH-1:0] wdata;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic                  was_empty;
    logic                  done_reg;
    logic                  rd_ok_reg;
    logic [ST_W-1:0]       status_reg;
    logic [DATA_WIDTH-1:0] front_copy_reg;
    logic [DATA_WIDTH-1:0] front_copy_next;
    logic [DATA_WIDTH-1:0] back_copy_reg;
    logic [DATA_WIDTH-1:0] back_copy_next;

    // Every operation does its memory access at the edge that takes it, and a write
    // always lands before the next read is issued, so no interlock is needed.
    assign busy  = 1'b0;
    assign take  = start && !busy;
    assign wdata = DATA_WIDTH'(value);

    deqi_ptr u_ptr (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .opcode   (opcode),
        .position (position),
        .ctl      (ctl),
        .count    (count)
    );

    deqi_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (take && ctl.wr_en),
        .addr  (ctl.addr),
        .wdata (wdata),
        .rdata (ram_rdata)
    );

    // The end copies track the front and back elements so that every result
    // can show them without a second memory read. The first push into an
    // empty queue sets both ends.
    always_comb
    begin
        was_empty       = (count == '0);
        front_copy_next = front_copy_reg;
        back_copy_next  = back_copy_reg;
        if (ctl.wr_en)
        begin
            if (opcode == OP_PUSH_FRONT)
            begin
                front_copy_next = wdata;
                if (was_empty)
                begin
                    back_copy_next = wdata;
                end
            end
            else
            begin
                back_copy_next = wdata;
                if (was_empty)
                begin
                    front_copy_next = wdata;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg       <= 1'b0;
            rd_ok_reg      <= 1'b0;
            status_reg     <= ST_OK;
            front_copy_reg <= '0;
            back_copy_reg  <= '0;
        end
        else
        begin
            done_reg <= take;
            if (take)
            begin
                rd_ok_reg      <= ctl.rd_ok;
                status_reg     <= ctl.status;
                front_copy_reg <= front_copy_next;
                back_copy_reg  <= back_copy_next;
            end
        end
    end

    // The result cycle shows the state left by the operation just taken;
    // a following command only changes it at the end of this cycle.
    assign done          = done_reg;
    assign ends_valid    = (count != '0);
    assign is_empty      = (count == '0);
    assign element_count = CNTO_W'(count);
    assign status        = status_reg;
    assign read_data     = rd_ok_reg ? VAL_W'(ram_rdata) : '0;
    assign front_value   = ends_valid ? VAL_W'(front_copy_reg) : '0;
    assign back_value    = ends_valid ? VAL_W'(back_copy_reg) : '0;

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> done)
        else $error("command transfer without a result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> !done)
        else $error("result without a command transfer");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (element_count == CNTO_W'(DEPTH)))
        else $error("push refused while queue not full");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (take && ctl.wr_en) |=> (count == $past(count) + CNT_W'(1)))
        else $error("accepted push did not grow the queue");

endmodule

### tb/deqi_checker.sv
`timescale 1ns / 1ps

module deqi_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [deqi_pkg::OP_W-1:0]   opcode,
    input  logic [deqi_pkg::VAL_W-1:0]  value,
    input  logic [deqi_pkg::POS_W-1:0]  position,
    input  logic                        done,
    input  logic [deqi_pkg::VAL_W-1:0]  read_data,
    input  logic [deqi_pkg::VAL_W-1:0]  front_value,
    input  logic [deqi_pkg::VAL_W-1:0]  back_value,
    input  logic                        ends_valid,
    input  logic [deqi_pkg::CNTO_W-1:0] element_count,
    input  logic                        is_empty,
    input  logic [deqi_pkg::ST_W-1:0]   status,
    output int                          failures,
    output int                          pending,
    output int                          results_seen,
    output int                          reads_hit,
    output int                          reads_missed,
    output int                          pushes_refused
);

    import deqi_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0]  rd;
        logic [VAL_W-1:0]  fv;
        logic [VAL_W-1:0]  bv;
        logic              ev;
        logic [CNTO_W-1:0] cnt;
        logic              emp;
        logic [ST_W-1:0]   st;
    } deqi_result_t;

    // Shadow copy of the ring buffer and its bookkeeping.
    logic [VAL_W-1:0]  ring_mem [DEPTH];
    logic [ADDR_W-1:0] head_slot = '0;
    logic [CNT_W-1:0]  fill      = '0;
    logic [VAL_W-1:0]  front_q   = '0;
    logic [VAL_W-1:0]  back_q    = '0;

    deqi_result_t expected_q[$];

    int fail_total  = 0;
    int outstanding = 0;
    int seen_total  = 0;
    int hit_total   = 0;
    int miss_total  = 0;
    int full_total  = 0;

    assign failures       = fail_total;
    assign pending        = outstanding;
    assign results_seen   = seen_total;
    assign reads_hit      = hit_total;
    assign reads_missed   = miss_total;
    assign pushes_refused = full_total;

    // Applies one operation to the shadow queue and returns what the block should report.
    function automatic deqi_result_t apply_op(input logic [OP_W-1:0]  op,
                                              input logic [VAL_W-1:0] val,
                                              input logic [POS_W-1:0] pos);
        deqi_result_t r;
        logic         was_empty;
        r    = '0;
        r.st = ST_OK;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (fill >= DEPTH) begin
                    r.st = ST_FULL;
                end else begin
                    was_empty = (fill == 0);
                    if (op == OP_PUSH_FRONT) begin
                        head_slot           = head_slot - 1'b1;
                        ring_mem[head_slot] = val;
                        front_q             = val;
                        if (was_empty)
                            back_q = val;
                    end else begin
                        ring_mem[ADDR_W'(head_slot + fill)] = val;
                        back_q                              = val;
                        if (was_empty)
                            front_q = val;
                    end
                    fill = fill + 1'b1;
                end
            end
            OP_READ:
            begin
                if (CNT_W'(pos) >= fill)
                    r.st = ST_RANGE;
                else
                    r.rd = ring_mem[ADDR_W'(head_slot + pos)];
            end
            default:
            begin
            end
        endcase
        r.ev  = (fill != 0);
        r.emp = (fill == 0);
        r.fv  = r.ev ? front_q : '0;
        r.bv  = r.ev ? back_q : '0;
        r.cnt = CNTO_W'(fill);
        return r;
    endfunction

    function automatic int field_differs(input string name, input logic [VAL_W-1:0] want,
                                         input logic [VAL_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk)
    begin : monitor
        deqi_result_t want;
        int           errs;
        errs = 0;
        if (rst_n) begin
            if (done === 1'b1) begin
                if (expected_q.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    errs = 1;
                end else begin
                    want = expected_q.pop_front();
                    seen_total++;
                    errs += field_differs("read_data", want.rd, read_data);
                    errs += field_differs("front_value", want.fv, front_value);
                    errs += field_differs("back_value", want.bv, back_value);
                    errs += field_differs("ends_valid", want.ev, ends_valid);
                    errs += field_differs("element_count", want.cnt, element_count);
                    errs += field_differs("is_empty", want.emp, is_empty);
                    errs += field_differs("status", want.st, status);
                    if (want.st == ST_RANGE)
                        miss_total++;
                    else if (want.st == ST_FULL)
                        full_total++;
                    else if (want.rd != '0 || CNT_W'(0) != want.cnt)
                        hit_total += 0;
                end
            end
            if (start === 1'b1 && busy !== 1'b1) begin
                if (opcode == OP_READ && CNT_W'(position) < fill)
                    hit_total++;
                expected_q.insert(expected_q.size(), apply_op(opcode, value, position));
            end
        end
        fail_total  <= fail_total + errs;
        outstanding <= expected_q.size();
    end

endmodule

### tb/double_ended_queue_indexed_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the indexed double-ended queue. The checker instance beside the
// block watches both channels, keeps its own copy of the queue, and reports failures here.
module double_ended_queue_indexed_tb;
    import deqi_pkg::*;

    // The block has no code for opcode 3; it must act as a no-op.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int N_RANDOM    = 1250;
    // Worst case is about 1300 commands, each behind a geometric idle gap,
    // plus reset and a drain; this limit leaves a wide margin over that.
    localparam int CYCLE_LIMIT = 200000;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              start    = 1'b0;
    logic [OP_W-1:0]   opcode   = '0;
    logic [VAL_W-1:0]  value    = '0;
    logic [POS_W-1:0]  position = '0;

    logic              busy;
    logic              done;
    logic [VAL_W-1:0]  read_data;
    logic [VAL_W-1:0]  front_value;
    logic [VAL_W-1:0]  back_value;
    logic              ends_valid;
    logic [CNTO_W-1:0] element_count;
    logic              is_empty;
    logic [ST_W-1:0]   status;

    int failures;
    int pending;
    int results_seen;
    int reads_hit;
    int reads_missed;
    int pushes_refused;

    // Percentage of cycles in which the sender holds start low before the next transfer.
    int idle_pct  = 0;
    // Rough element count as seen from the stimulus side, used only to aim reads in range.
    int fill_seen = 0;
    int cycles    = 0;

    always #6 clk = ~clk;

    double_ended_queue_indexed u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .value         (value),
        .position      (position),
        .done          (done),
        .read_data     (read_data),
        .front_value   (front_value),
        .back_value    (back_value),
        .ends_valid    (ends_valid),
        .element_count (element_count),
        .is_empty      (is_empty),
        .status        (status)
    );

    deqi_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .value          (value),
        .position       (position),
        .done           (done),
        .read_data      (read_data),
        .front_value    (front_value),
        .back_value     (back_value),
        .ends_valid     (ends_valid),
        .element_count  (element_count),
        .is_empty       (is_empty),
        .status         (status),
        .failures       (failures),
        .pending        (pending),
        .results_seen   (results_seen),
        .reads_hit      (reads_hit),
        .reads_missed   (reads_missed),
        .pushes_refused (pushes_refused)
    );

    // A hung handshake must not stall the run forever.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("double_ended_queue_indexed_tb: FAIL");
            $finish;
        end
    end

    // Drives one command and returns at the edge where its transfer happens. Idle cycles
    // go in front of it with random junk on the payload, which the block must ignore.
    task automatic issue(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
                         input logic [POS_W-1:0] pos);
        while ($urandom_range(99) < idle_pct) begin
            start    <= 1'b0;
            opcode   <= OP_W'($urandom);
            value    <= $urandom;
            position <= POS_W'($urandom);
            @(posedge clk);
        end
        start    <= 1'b1;
        opcode   <= op;
        value    <= val;
        position <= pos;
        @(posedge clk);
        while (busy === 1'b1)
            @(posedge clk);
        if ((op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && fill_seen < DEPTH)
            fill_seen++;
    endtask

    // Holds start low until every result owed for past transfers has come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Element data with the all-zero and all-one words mixed in often.
    function automatic logic [VAL_W-1:0] data_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic int idle_for_phase(input int phase);
        case (phase)
            1:       return 69;
            3:       return 27;
            default: return 0;
        endcase
    endfunction

    // Pushes make up about forty percent, so the queue fills a little past the halfway
    // point of the run; the rest then exercises refused pushes and reads of a full queue.
    // Most reads aim inside the live range so they return stored data.
    task automatic random_item();
        int               pick;
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        pick = $urandom_range(99);
        pos  = POS_W'($urandom);
        if (pick < 4) begin
            op = OP_UNUSED;
        end else if (pick < 44) begin
            op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        end else begin
            op = OP_READ;
            if (fill_seen > 0 && $urandom_range(9) < 8)
                pos = POS_W'($urandom_range(fill_seen - 1));
        end
        issue(op, data_word(), pos);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Empty queue: reads at both ends of the index range fall out of range, and the
        // unused opcode reports the empty state.
        issue(OP_READ, '1, 8'd0);
        issue(OP_READ, '0, 8'd255);
        issue(OP_UNUSED, 32'hDEAD_BEEF, 8'd17);

        // First push into an empty queue sets both ends at once.
        issue(OP_PUSH_BACK, 32'hFFFF_FFFF, 8'd255);
        issue(OP_READ, '0, 8'd0);
        issue(OP_READ, '0, 8'd1);

        // Front pushes move the head below slot zero, so later reads wrap the ring.
        issue(OP_PUSH_FRONT, 32'h0000_0000, 8'd0);
        issue(OP_PUSH_FRONT, 32'hA5A5_A5A5, 8'd128);
        issue(OP_PUSH_BACK, 32'h5A5A_5A5A, 8'd64);
        issue(OP_PUSH_BACK, 32'h8000_0001, 8'd3);
        issue(OP_READ, '0, 8'd0);
        issue(OP_READ, '0, 8'd1);
        issue(OP_READ, '0, 8'd2);
        issue(OP_READ, '0, 8'd4);
        issue(OP_READ, '0, 8'd5);
        issue(OP_READ, '0, 8'd128);
        issue(OP_READ, '0, 8'd255);
        issue(OP_UNUSED, '1, 8'd2);
        issue(OP_PUSH_FRONT, 32'h7FFF_FFFE, 8'd200);
        issue(OP_READ, '1, 8'd0);
        issue(OP_READ, '1, 8'd5);

        // Random part in four phases of sender idling: none, heavy, none, light.
        for (int i = 0; i < N_RANDOM; i++) begin
            idle_pct = idle_for_phase((i * 4) / N_RANDOM);
            if (i == N_RANDOM / 2)
                drain();
            random_item();
        end

        drain();
        repeat (4) @(posedge clk);

        $display("Checked %0d results: %0d reads in range, %0d reads out of range, %0d pushes refused",
                 results_seen, reads_hit, reads_missed, pushes_refused);
        $display("The queue was driven from empty to full under back-to-back and idling traffic.");
        if (failures == 0 && pending == 0) begin
            $display("double_ended_queue_indexed_tb: PASS");
        end else begin
            $display("double_ended_queue_indexed_tb: FAIL");
        end
        $finish;
    end

endmodule

### sim.f
sv/deqi_pkg.sv
sv/deqi_ram.sv
sv/deqi_ptr.sv
sv/double_ended_queue_indexed.sv
tb/deqi_checker.sv
tb/double_ended_queue_indexed_tb.sv
